### sv/bps_pkg.sv
// bilinear pixel scaler package: widths, register indexes, shared types
// and the channel mask function. no dependencies.
package bps_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 12;
  localparam int CHANNELS  = 4;

  localparam int CH_W      = 8;
  localparam int PIX_W     = 32;
  localparam int NUM_NB    = 4;
  localparam int POS_W     = 25;
  localparam int STEP_W    = 24;
  localparam int DIM_W     = 12;
  localparam int COORD_W   = 13;
  localparam int WGT_W     = 2 * FRAC_BITS + 1;
  localparam int PROD_W    = 2 * FRAC_BITS + CH_W;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [DIM_W-1:0]   DIM_LAST =
    (MAX_DIM - 1 > (1 << DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM - 1);

  localparam logic [2:0] BPP_GREY = 3'd1;
  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBA = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAREST  = 3'd0,
    CFG_BPP      = 3'd1,
    CFG_STEP_X   = 3'd2,
    CFG_STEP_Y   = 3'd3,
    CFG_LAST_COL = 3'd4,
    CFG_LAST_ROW = 3'd5,
    CFG_ORIGIN_X = 3'd6,
    CFG_ORIGIN_Y = 3'd7
  } cfg_idx_e;

  typedef logic [FRAC_BITS:0]                frac_t;
  typedef logic [NUM_NB-1:0][WGT_W-1:0]      wgt_t;
  typedef logic [NUM_NB-1:0][PIX_W-1:0]      nb_t;

  typedef struct packed {
    logic              nearest;
    logic [2:0]        bpp;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [DIM_W-1:0]  last_col;
    logic [DIM_W-1:0]  last_row;
    logic [DIM_W-1:0]  origin_x;
    logic [DIM_W-1:0]  origin_y;
  } cfg_t;

  typedef struct packed {
    logic [CHANNELS-1:0] act;
    logic [COORD_W-1:0]  next_x;
    logic [COORD_W-1:0]  next_y;
    logic                row_end;
    logic                frame_end;
  } meta_t;

  function automatic logic [CHANNELS-1:0] chan_mask(input logic [2:0] bpp);
    logic [3:0] m;
    case (bpp)
      BPP_GREY: m = 4'b0001;
      BPP_RGB:  m = 4'b0111;
      BPP_RGBA: m = 4'b1111;
      default:  m = 4'b0000;
    endcase
    return m[CHANNELS-1:0];
  endfunction

endpackage

### sv/bps_if.sv
// word channels of the bilinear pixel scaler: neighbourhood in, pixel out
// depends on bps_pkg for field widths
interface bps_in_if;
  logic                       valid;
  logic                       ready;
  logic [bps_pkg::PIX_W-1:0]  top_left;
  logic [bps_pkg::PIX_W-1:0]  top_right;
  logic [bps_pkg::PIX_W-1:0]  bottom_left;
  logic [bps_pkg::PIX_W-1:0]  bottom_right;

  modport source (output valid, top_left, top_right, bottom_left, bottom_right,
                  input ready);
  modport sink   (input valid, top_left, top_right, bottom_left, bottom_right,
                  output ready);
endinterface

interface bps_out_if;
  logic                        valid;
  logic                        ready;
  logic [bps_pkg::PIX_W-1:0]   out_pixel;
  logic [bps_pkg::COORD_W-1:0] next_src_x;
  logic [bps_pkg::COORD_W-1:0] next_src_y;
  logic                        row_end;
  logic                        frame_end;

  modport source (output valid, out_pixel, next_src_x, next_src_y, row_end, frame_end,
                  input ready);
  modport sink   (input valid, out_pixel, next_src_x, next_src_y, row_end, frame_end,
                  output ready);
endinterface

### sv/bps_ctrl.sv
// configuration registers and source position tracking
// depends on bps_pkg
module bps_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bps_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            acc_i,
  output bps_pkg::frac_t                  tx_o,
  output bps_pkg::frac_t                  ty_o,
  output bps_pkg::meta_t                  meta_o
);
  import bps_pkg::*;

  cfg_t             cfg_q;
  logic [POS_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [DIM_W-1:0] col_q, col_d, row_q, row_d;
  logic [DIM_W-1:0] lim_col, lim_row;
  logic             row_end, frame_end;
  logic [POS_W:0]   sum_x, sum_y;
  logic [POS_W-1:0] inc_x, inc_y, origin_pos;
  logic [COORD_W:0] nx;
  logic             origin_load;

  function automatic frac_t frac_of(input logic [POS_W-1:0] pos, input logic nearest);
    frac_t f;
    if (nearest) begin
      f = {pos[FRAC_BITS-1], {FRAC_BITS{1'b0}}};
    end else begin
      f = {1'b0, pos[FRAC_BITS-1:0]};
    end
    return f;
  endfunction

  assign tx_o = frac_of(pos_x_q, cfg_q.nearest);
  assign ty_o = frac_of(pos_y_q, cfg_q.nearest);

  assign lim_col   = (cfg_q.last_col > DIM_LAST) ? DIM_LAST : cfg_q.last_col;
  assign lim_row   = (cfg_q.last_row > DIM_LAST) ? DIM_LAST : cfg_q.last_row;
  assign row_end   = col_q >= lim_col;
  assign frame_end = row_end && (row_q >= lim_row);

  // saturating position steps
  assign sum_x = {1'b0, pos_x_q} + (POS_W + 1)'(cfg_q.step_x);
  assign sum_y = {1'b0, pos_y_q} + (POS_W + 1)'(cfg_q.step_y);
  assign inc_x = sum_x[POS_W] ? {POS_W{1'b1}} : sum_x[POS_W-1:0];
  assign inc_y = sum_y[POS_W] ? {POS_W{1'b1}} : sum_y[POS_W-1:0];
  assign origin_pos = POS_W'({cfg_q.origin_y, {FRAC_BITS{1'b0}}});

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    col_d   = col_q;
    row_d   = row_q;
    if (frame_end) begin
      pos_x_d = '0;
      pos_y_d = origin_pos;
      col_d   = '0;
      row_d   = '0;
    end else if (row_end) begin
      pos_x_d = '0;
      pos_y_d = inc_y;
      col_d   = '0;
      row_d   = row_q + DIM_W'(1);
    end else begin
      pos_x_d = inc_x;
      col_d   = col_q + DIM_W'(1);
    end
  end

  // reported coordinates follow the stepped position
  assign nx = (COORD_W + 1)'(cfg_q.origin_x) + (COORD_W + 1)'(pos_x_d[POS_W-1:FRAC_BITS]);

  always_comb begin
    meta_o.act       = chan_mask(cfg_q.bpp);
    meta_o.next_x    = nx[COORD_W] ? {COORD_W{1'b1}} : nx[COORD_W-1:0];
    meta_o.next_y    = pos_y_d[POS_W-1:FRAC_BITS];
    meta_o.row_end   = row_end;
    meta_o.frame_end = frame_end;
  end

  // origin row write at frame start reloads the vertical position
  assign origin_load = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_ORIGIN_Y) &&
                       (col_q == '0) && (row_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nearest  <= 1'b0;
      cfg_q.bpp      <= BPP_RGBA;
      cfg_q.step_x   <= STEP_W'(FRAC_ONE);
      cfg_q.step_y   <= STEP_W'(FRAC_ONE);
      cfg_q.last_col <= '0;
      cfg_q.last_row <= '0;
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAREST:  cfg_q.nearest  <= cfg_wdata_i[0];
        CFG_BPP:      cfg_q.bpp      <= cfg_wdata_i[2:0];
        CFG_STEP_X:   cfg_q.step_x   <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Y:   cfg_q.step_y   <= cfg_wdata_i[STEP_W-1:0];
        CFG_LAST_COL: cfg_q.last_col <= cfg_wdata_i[DIM_W-1:0];
        CFG_LAST_ROW: cfg_q.last_row <= cfg_wdata_i[DIM_W-1:0];
        CFG_ORIGIN_X: cfg_q.origin_x <= cfg_wdata_i[DIM_W-1:0];
        CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (acc_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end else if (origin_load) begin
      pos_y_q <= POS_W'({cfg_wdata_i[DIM_W-1:0], {FRAC_BITS{1'b0}}});
    end
  end

endmodule

### sv/bps_weight.sv
// bilinear weight stage: four 13x13 products of the fractions, registered
// depends on bps_pkg
module bps_weight (
  input  logic            clk_i,
  input  logic            en_i,
  input  bps_pkg::frac_t  tx_i,
  input  bps_pkg::frac_t  ty_i,
  output bps_pkg::wgt_t   w_o
);
  import bps_pkg::*;

  frac_t inv_tx, inv_ty;
  wgt_t  w_q;

  assign inv_tx = FRAC_ONE - tx_i;
  assign inv_ty = FRAC_ONE - ty_i;

  // weights in neighbour order: top left, top right, bottom left, bottom right
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= WGT_W'(inv_tx * inv_ty);
      w_q[1] <= WGT_W'(tx_i * inv_ty);
      w_q[2] <= WGT_W'(inv_tx * ty_i);
      w_q[3] <= WGT_W'(tx_i * ty_i);
    end
  end

  assign w_o = w_q;

endmodule

### sv/bps_lane.sv
// one channel lane: weighted products registered, then summed and scaled
// depends on bps_pkg
module bps_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  bps_pkg::wgt_t                w_i,
  input  logic [bps_pkg::NUM_NB-1:0][bps_pkg::CH_W-1:0] chan_i,
  output logic [bps_pkg::CH_W-1:0]     chan_o
);
  import bps_pkg::*;

  logic [NUM_NB-1:0][PROD_W-1:0] prod_q;
  logic [PROD_W+1:0]             sum;
  logic [CH_W-1:0]               chan_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < NUM_NB; n++) begin
        prod_q[n] <= PROD_W'(w_i[n] * chan_i[n]);
      end
    end
  end

  // weights add up to one, so the sum never leaves PROD_W bits
  assign sum = (PROD_W + 2)'(prod_q[0]) + (PROD_W + 2)'(prod_q[1]) +
               (PROD_W + 2)'(prod_q[2]) + (PROD_W + 2)'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q <= sum[2*FRAC_BITS +: CH_W];
    end
  end

  assign chan_o = chan_q;

endmodule

### sv/bilinear_pixel_scaler.sv
// bilinear pixel scaler top level: position control, weight stage,
// per-channel lanes and merge into the output register. uses bps_pkg, bps_if
// pipeline: an accepted word passes the input, weight, product and lane output registers
// throughput: one word per cycle while the output is taken; the pipeline
// stalls as a whole when the output register holds an untaken word
// reset: asynchronous active low, clears valids and positions, sets config registers to defaults
module bilinear_pixel_scaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bps_pkg::CFG_W-1:0]      cfg_wdata_i,
  bps_in_if.sink                         in_i,
  bps_out_if.source                      out_o
);
  import bps_pkg::*;

  logic  adv, acc;
  frac_t tx, ty, tx1_q, ty1_q;
  meta_t meta, meta1_q, meta2_q, meta3_q, meta4_q;
  nb_t   pix1_q, pix2_q;
  wgt_t  w;
  logic  v1_q, v2_q, v3_q, v4_q;
  logic [CHANNELS-1:0][CH_W-1:0] lane_chan;
  logic [PIX_W-1:0] pix_out;

  assign adv       = !v4_q || out_o.ready;
  assign acc       = in_i.valid && adv;
  assign in_i.ready = adv;

  bps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .tx_o        (tx),
    .ty_o        (ty),
    .meta_o      (meta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx1_q   <= tx;
      ty1_q   <= ty;
      meta1_q <= meta;
      pix1_q  <= {in_i.bottom_right, in_i.bottom_left, in_i.top_right, in_i.top_left};
      meta2_q <= meta1_q;
      pix2_q  <= pix1_q;
      meta3_q <= meta2_q;
      meta4_q <= meta3_q;
    end
  end

  bps_weight u_weight (
    .clk_i (clk_i),
    .en_i  (adv),
    .tx_i  (tx1_q),
    .ty_i  (ty1_q),
    .w_o   (w)
  );

  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    logic [NUM_NB-1:0][CH_W-1:0] chan;
    for (genvar n = 0; n < NUM_NB; n++) begin : g_nb
      assign chan[n] = pix2_q[n][CH_W*k +: CH_W];
    end
    bps_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .w_i    (w),
      .chan_i (chan),
      .chan_o (lane_chan[k])
    );
  end

  // merge lanes, inactive channels read zero
  always_comb begin
    pix_out = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      pix_out[CH_W*k +: CH_W] = meta4_q.act[k] ? lane_chan[k] : '0;
    end
  end

  assign out_o.valid      = v4_q;
  assign out_o.out_pixel  = pix_out;
  assign out_o.next_src_x = meta4_q.next_x;
  assign out_o.next_src_y = meta4_q.next_y;
  assign out_o.row_end    = meta4_q.row_end;
  assign out_o.frame_end  = meta4_q.frame_end;

endmodule

### sv/bps_checker.sv
// port-level checks for the bilinear pixel scaler, bound to the top level
// depends on bps_pkg
module bps_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bps_pkg::PIX_W-1:0]     out_pixel_i,
  input  logic                          row_end_i,
  input  logic                          frame_end_i
);

  // a stalled result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i))
    else $error("output word changed while stalled");

  // last pixel of the frame is also last of its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> row_end_i)
    else $error("frame end without row end");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

  // no word gets through the pipeline in fewer than its stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && !in_valid_i) ##1 in_ready_i ##1 in_ready_i ##1 in_ready_i
    |=> !out_valid_i)
    else $error("output appeared too early");

endmodule

bind bilinear_pixel_scaler bps_checker u_bps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pixel_i (out_o.out_pixel),
  .row_end_i   (out_o.row_end),
  .frame_end_i (out_o.frame_end)
);

### bench/tb_bilinear_pixel_scaler.sv
`timescale 1ns / 1ps
// testbench for bilinear_pixel_scaler: drives neighbourhood words and register
// writes, predicts each scaled pixel and checks it. needs bps_pkg, bps_if and
// the scaler rtl
module tb_bilinear_pixel_scaler;
  import bps_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS  = 850;
  localparam int unsigned SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic               row_end;
    logic               frame_end;
  } scaled_pixel_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  bps_in_if  nb_if ();
  bps_out_if px_if ();

  bilinear_pixel_scaler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (nb_if),
    .out_o       (px_if)
  );

  // scaler copy: registers and position state
  logic              m_nearest;
  logic [2:0]        m_bpp;
  logic [STEP_W-1:0] m_step_x, m_step_y;
  logic [DIM_W-1:0]  m_last_col, m_last_row, m_origin_x, m_origin_y;
  logic [POS_W-1:0]  pos_x, pos_y;
  logic [DIM_W-1:0]  out_col, out_row;

  scaled_pixel_t expected_px[$];
  scaled_pixel_t got_px, want_px;
  int unsigned   mismatches;
  int unsigned   cycles;
  int unsigned   stall_left;
  bit            in_gaps, out_stalls;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [FRAC_BITS:0] frac_weight(input logic [FRAC_BITS-1:0] f);
    if (m_nearest) return f[FRAC_BITS-1] ? FRAC_ONE : '0;
    return {1'b0, f};
  endfunction

  function automatic logic [POS_W-1:0] pos_advance(input logic [POS_W-1:0] p,
                                                   input logic [STEP_W-1:0] s);
    logic [POS_W:0] sum;
    sum = p + s;
    return sum[POS_W] ? '1 : sum[POS_W-1:0];
  endfunction

  // one output pixel from the current position, then step the position
  function automatic scaled_pixel_t interpolate_pixel(input logic [PIX_W-1:0] tl, tr, bl, br);
    logic [FRAC_BITS:0] tx, ty;
    logic [63:0]        w00, w01, w10, w11, sum;
    logic [COORD_W:0]   nx;
    int                 active;
    scaled_pixel_t      r;
    tx  = frac_weight(pos_x[FRAC_BITS-1:0]);
    ty  = frac_weight(pos_y[FRAC_BITS-1:0]);
    w00 = (64'(FRAC_ONE) - tx) * (64'(FRAC_ONE) - ty);
    w01 = 64'(tx) * (64'(FRAC_ONE) - ty);
    w10 = (64'(FRAC_ONE) - tx) * 64'(ty);
    w11 = 64'(tx) * 64'(ty);
    case (m_bpp)
      BPP_GREY: active = 1;
      BPP_RGB:  active = 3;
      BPP_RGBA: active = 4;
      default:  active = 0;
    endcase
    if (active > CHANNELS) active = CHANNELS;
    r = '0;
    for (int k = 0; k < active; k++) begin
      sum = w00 * tl[8*k +: 8] + w01 * tr[8*k +: 8] + w10 * bl[8*k +: 8]
          + w11 * br[8*k +: 8];
      r.pixel[8*k +: 8] = sum[2*FRAC_BITS +: 8];
    end
    r.row_end   = out_col >= m_last_col;
    r.frame_end = r.row_end && (out_row >= m_last_row);
    if (r.frame_end) begin
      out_col = '0;
      out_row = '0;
      pos_x   = '0;
      pos_y   = POS_W'(m_origin_y) << FRAC_BITS;
    end else if (r.row_end) begin
      out_col = '0;
      out_row = out_row + 1'b1;
      pos_x   = '0;
      pos_y   = pos_advance(pos_y, m_step_y);
    end else begin
      out_col = out_col + 1'b1;
      pos_x   = pos_advance(pos_x, m_step_x);
    end
    nx       = m_origin_x + pos_x[POS_W-1:FRAC_BITS];
    r.next_x = (nx > 8191) ? '1 : nx[COORD_W-1:0];
    r.next_y = pos_y[POS_W-1:FRAC_BITS];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0:       p[8*k +: 8] = 8'h00;
        1:       p[8*k +: 8] = 8'hff;
        default: p[8*k +: 8] = 8'($urandom());
      endcase
    end
    return p;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DIM_W'($urandom());
      default: return DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'hfff000;
      2:       return STEP_W'($urandom_range(0, 24'hfff000));
      default: return STEP_W'($urandom_range(24'h000200, 24'h003000));
    endcase
  endfunction

  // junk goes into the bits above the register width, the block must ignore it
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    int unsigned      w;
    logic [CFG_W-1:0] junk;
    case (idx)
      CFG_NEAREST:           w = 1;
      CFG_BPP:               w = 3;
      CFG_STEP_X, CFG_STEP_Y: w = 24;
      default:               w = 12;
    endcase
    junk = CFG_W'($urandom());
    if (w < CFG_W) value = (value & ((CFG_W'(1) << w) - 1'b1)) | (junk << w);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_NEAREST:  m_nearest  = value[0];
      CFG_BPP:      m_bpp      = value[2:0];
      CFG_STEP_X:   m_step_x   = value[STEP_W-1:0];
      CFG_STEP_Y:   m_step_y   = value[STEP_W-1:0];
      CFG_LAST_COL: m_last_col = value[DIM_W-1:0];
      CFG_LAST_ROW: m_last_row = value[DIM_W-1:0];
      CFG_ORIGIN_X: m_origin_x = value[DIM_W-1:0];
      CFG_ORIGIN_Y: begin
        m_origin_y = value[DIM_W-1:0];
        // only reloads the position at the very start of a frame
        if (out_col == 0 && out_row == 0) pos_y = POS_W'(m_origin_y) << FRAC_BITS;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [PIX_W-1:0] tl, tr, bl, br);
    int unsigned gap;
    gap = in_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      nb_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    nb_if.valid        <= 1'b1;
    nb_if.top_left     <= tl;
    nb_if.top_right    <= tr;
    nb_if.bottom_left  <= bl;
    nb_if.bottom_right <= br;
    do @(posedge clk_i); while (!nb_if.ready);
    expected_px.push_back(interpolate_pixel(tl, tr, bl, br));
  endtask

  task automatic send_random_word();
    send_word(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    nb_if.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
  endtask

  // idle point for register writes
  task automatic quiesce();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("mismatch at %0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (out_stalls && stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      px_if.ready <= 1'b0;
      stall_left--;
    end else begin
      px_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && px_if.valid && px_if.ready) begin
      got_px = '{px_if.out_pixel, px_if.next_src_x, px_if.next_src_y,
                 px_if.row_end, px_if.frame_end};
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("mismatch at %0t: word with nothing expected, pixel %h", $time,
                   got_px.pixel);
      end else begin
        want_px = expected_px.pop_front();
        compare_field("out_pixel", want_px.pixel, got_px.pixel);
        compare_field("next_src_x", want_px.next_x, got_px.next_x);
        compare_field("next_src_y", want_px.next_y, got_px.next_y);
        compare_field("row_end", want_px.row_end, got_px.row_end);
        compare_field("frame_end", want_px.frame_end, got_px.frame_end);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d words outstanding", expected_px.size());
      $display("[bilinear_pixel_scaler] ERROR");
      $finish;
    end
  end

  // default registers: full rgba, unit steps, one pixel per frame
  task automatic test_reset_defaults();
    send_word('0, '0, '0, '0);
    send_word('1, '1, '1, '1);
  endtask

  task automatic test_channel_formats();
    quiesce();
    write_reg(CFG_LAST_COL, 3);
    write_reg(CFG_LAST_ROW, 1);
    write_reg(CFG_STEP_X, 24'h000555);
    write_reg(CFG_STEP_Y, 24'h000a00);
    for (int b = 0; b < 8; b++) begin
      quiesce();
      write_reg(CFG_BPP, CFG_W'(b));
      send_random_word();
    end
  endtask

  // fractions just below and at one half
  task automatic test_nearest_mode();
    quiesce();
    write_reg(CFG_BPP, CFG_W'(BPP_RGBA));
    write_reg(CFG_NEAREST, 1);
    write_reg(CFG_STEP_X, 24'h0007ff);
    write_reg(CFG_STEP_Y, 24'h000800);
    write_reg(CFG_LAST_COL, 3);
    write_reg(CFG_LAST_ROW, 3);
    repeat (4) send_random_word();
    quiesce();
    write_reg(CFG_NEAREST, 0);
  endtask

  task automatic test_position_saturation();
    quiesce();
    write_reg(CFG_LAST_COL, 4095);
    write_reg(CFG_LAST_ROW, 4095);
    write_reg(CFG_STEP_X, 24'hfff000);
    write_reg(CFG_STEP_Y, 24'hfff000);
    write_reg(CFG_ORIGIN_X, 4095);
    repeat (3) send_random_word();
    quiesce();
    write_reg(CFG_LAST_COL, 0);
    repeat (3) send_random_word();
  endtask

  task automatic test_origin_reload();
    quiesce();
    write_reg(CFG_LAST_COL, 0);
    write_reg(CFG_LAST_ROW, 0);
    send_random_word();
    quiesce();
    // at frame start: takes effect at once
    write_reg(CFG_ORIGIN_Y, 4095);
    write_reg(CFG_ORIGIN_X, 0);
    write_reg(CFG_STEP_X, 24'h001800);
    write_reg(CFG_STEP_Y, 24'h001800);
    write_reg(CFG_LAST_COL, 2);
    write_reg(CFG_LAST_ROW, 2);
    repeat (2) send_random_word();
    quiesce();
    // mid-frame: waits for the next frame
    write_reg(CFG_ORIGIN_Y, 100);
    repeat (7) send_random_word();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, n;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      quiesce();
      write_reg(CFG_NEAREST, CFG_W'($urandom_range(0, 1)));
      write_reg(CFG_BPP, CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                ($urandom_range(0, 2) == 0) ? BPP_GREY :
                ($urandom_range(0, 1) == 0) ? BPP_RGB : BPP_RGBA));
      write_reg(CFG_STEP_X, pick_step());
      write_reg(CFG_STEP_Y, pick_step());
      write_reg(CFG_LAST_COL, pick_dim());
      write_reg(CFG_LAST_ROW, pick_dim());
      write_reg(CFG_ORIGIN_X, pick_dim() == 0 ? '0 : DIM_W'($urandom()));
      write_reg(CFG_ORIGIN_Y, pick_dim() == 0 ? '1 : DIM_W'($urandom()));
      in_gaps    = $urandom_range(0, 3) != 0;
      out_stalls = $urandom_range(0, 3) != 0;
      n = $urandom_range(60, 130);
      repeat (n) begin
        if ($urandom_range(0, 79) == 0) hold_until_drained();
        send_random_word();
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_NEAREST;
    cfg_wdata          = '0;
    nb_if.valid        = 1'b0;
    nb_if.top_left     = '0;
    nb_if.top_right    = '0;
    nb_if.bottom_left  = '0;
    nb_if.bottom_right = '0;
    px_if.ready        = 1'b0;
    m_nearest          = 1'b0;
    m_bpp              = BPP_RGBA;
    m_step_x           = 24'h001000;
    m_step_y           = 24'h001000;
    m_last_col         = '0;
    m_last_row         = '0;
    m_origin_x         = '0;
    m_origin_y         = '0;
    pos_x              = '0;
    pos_y              = '0;
    out_col            = '0;
    out_row            = '0;
    mismatches         = 0;
    cycles             = 0;
    stall_left         = 0;
    in_gaps            = 1'b1;
    out_stalls         = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_channel_formats();
    test_nearest_mode();
    test_position_saturation();
    test_origin_reload();
    test_random_traffic();

    quiesce();
    if (mismatches == 0) begin
      $display("[bilinear_pixel_scaler] OK");
    end else begin
      $display("[bilinear_pixel_scaler] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bps_pkg.sv
sv/bps_if.sv
sv/bps_ctrl.sv
sv/bps_weight.sv
sv/bps_lane.sv
sv/bilinear_pixel_scaler.sv
sv/bps_checker.sv
bench/tb_bilinear_pixel_scaler.sv
